// ===== sv/bistable_seven_segment_updater_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the bistable seven-segment updater
// Shared assertion forms, compiled out when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef BISTABLE_SEVEN_SEGMENT_UPDATER_TOP_DEFINES_SVH
`define BISTABLE_SEVEN_SEGMENT_UPDATER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define BSSU_ASSERT_SAME(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("bssu assertion failed");
`define BSSU_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("bssu assertion failed");
`else
`define BSSU_ASSERT_SAME(label, clk, rst_n, cond, prop)
`define BSSU_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif

`endif

// ===== sv/bssu_pkg.sv =====
// ----------------------------------------------------------------------------
// bssu_pkg
// Types, constants and the digit pattern table of the seven-segment updater.
// ----------------------------------------------------------------------------
package bssu_pkg;

  localparam int DIGIT_COUNT = 4;
  localparam int SEGMENTS    = 7;

  localparam logic [6:0] PAT_BLANK = 7'h00;
  localparam logic [6:0] PAT_DASH  = 7'h40;

  localparam logic signed [7:0] LOW_LIMIT  = -8'sd9;
  localparam logic signed [7:0] HIGH_LIMIT = 8'sd99;

  localparam logic [2:0] LAST_SEG   = 3'(SEGMENTS - 1);
  localparam logic [1:0] LAST_DIGIT = 2'(DIGIT_COUNT - 1);

  typedef enum logic {
    OP_SHOW  = 1'b0,
    OP_CLEAR = 1'b1
  } opcode_t;

  typedef struct packed {
    opcode_t           opcode;
    logic signed [7:0] water_temp;
    logic signed [7:0] air_temp;
  } in_item_t;

  typedef struct packed {
    logic       is_flip;
    logic [1:0] digit_index;
    logic [2:0] segment_index;
    logic       turn_on;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic      load;
    out_item_t res;
  } step_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FMT,
    S_WALK,
    S_DONE
  } state_t;

  function automatic logic [6:0] digit_pattern(input logic [3:0] digit);
    logic [6:0] pat;
    case (digit)
      4'd0: pat = 7'h3F;
      4'd1: pat = 7'h06;
      4'd2: pat = 7'h5B;
      4'd3: pat = 7'h4F;
      4'd4: pat = 7'h66;
      4'd5: pat = 7'h6D;
      4'd6: pat = 7'h7D;
      4'd7: pat = 7'h07;
      4'd8: pat = 7'h7F;
      4'd9: pat = 7'h6F;
      default: pat = PAT_BLANK;
    endcase
    return pat;
  endfunction

endpackage

// ===== sv/bssu_fmt.sv =====
// ----------------------------------------------------------------------------
// bssu_fmt
// Formats one signed temperature into two seven-segment patterns.
// ----------------------------------------------------------------------------
module bssu_fmt (
  input  logic signed [7:0] temp,
  output logic [6:0]        hi_pat,
  output logic [6:0]        lo_pat
);
  import bssu_pkg::*;

  logic [7:0]  neg_mag;
  logic [14:0] prod;
  logic [3:0]  tens;
  logic [6:0]  tens_x10;
  logic [6:0]  units;

  assign neg_mag  = ~temp + 8'd1;
  assign prod     = {8'b0000_0000, temp[6:0]} * 15'd205;
  assign tens     = prod[14:11];
  assign tens_x10 = ({3'b000, tens} << 3) + ({3'b000, tens} << 1);
  assign units    = temp[6:0] - tens_x10;

  always_comb begin
    if (temp < LOW_LIMIT || temp > HIGH_LIMIT) begin
      hi_pat = PAT_DASH;
      lo_pat = PAT_DASH;
    end else if (temp[7]) begin
      hi_pat = PAT_DASH;
      lo_pat = digit_pattern(neg_mag[3:0]);
    end else if (temp < 8'sd10) begin
      hi_pat = PAT_BLANK;
      lo_pat = digit_pattern(temp[3:0]);
    end else begin
      hi_pat = digit_pattern(tens);
      lo_pat = digit_pattern(units[3:0]);
    end
  end

endmodule

// ===== sv/bssu_seq.sv =====
// ----------------------------------------------------------------------------
// bssu_seq
// Sequencer that walks all segments with one shared bit compare and keeps
// the patterns currently shown on the display.
// ----------------------------------------------------------------------------
`include "bistable_seven_segment_updater_top_defines.svh"

module bssu_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  bssu_pkg::in_item_t in_data,
  output logic               in_ready,
  input  logic               slot_free,
  output bssu_pkg::step_t    step
);
  import bssu_pkg::*;

  state_t            state_r, state_nxt;
  logic [1:0]        d_r;
  logic [2:0]        s_r;
  logic              clear_r;
  logic signed [7:0] water_r;
  logic signed [7:0] air_r;
  logic [6:0]        next_r  [DIGIT_COUNT];
  logic [6:0]        shown_r [DIGIT_COUNT];
  logic [6:0]        pat_w   [DIGIT_COUNT];
  logic              nb;
  logic              ob;
  logic              differ;
  logic              accept;

  bssu_fmt u_fmt_water (
    .temp   (water_r),
    .hi_pat (pat_w[0]),
    .lo_pat (pat_w[1])
  );

  bssu_fmt u_fmt_air (
    .temp   (air_r),
    .hi_pat (pat_w[2]),
    .lo_pat (pat_w[3])
  );

  assign accept = in_valid && in_ready;
  assign nb     = next_r[d_r][s_r];
  assign ob     = shown_r[d_r][s_r];
  assign differ = clear_r || (nb != ob);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_FMT;
        end
      end
      S_FMT: begin
        state_nxt = S_WALK;
      end
      S_WALK: begin
        if (slot_free && s_r == LAST_SEG && d_r == LAST_DIGIT) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    step     = '0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
      end
      S_WALK: begin
        step.load              = slot_free && differ;
        step.res.is_flip       = 1'b1;
        step.res.digit_index   = d_r;
        step.res.segment_index = s_r;
        step.res.turn_on       = nb;
      end
      S_DONE: begin
        step.load     = slot_free;
        step.res.last = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      clear_r <= (in_data.opcode == OP_CLEAR);
      water_r <= in_data.water_temp;
      air_r   <= in_data.air_temp;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_FMT) begin
      d_r <= '0;
      s_r <= '0;
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        next_r[i] <= clear_r ? PAT_BLANK : pat_w[i];
      end
    end else if (state_r == S_WALK && slot_free) begin
      if (s_r == LAST_SEG) begin
        s_r <= '0;
        d_r <= d_r + 2'd1;
      end else begin
        s_r <= s_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        shown_r[i] <= PAT_BLANK;
      end
    end else if (state_r == S_WALK && slot_free && s_r == LAST_SEG) begin
      shown_r[d_r] <= next_r[d_r];
    end
  end

  `BSSU_ASSERT_SAME(a_load_needs_slot, clk, rst_n, step.load, slot_free)
  `BSSU_ASSERT_SAME(a_clear_flips_all, clk, rst_n,
    state_r == S_WALK && clear_r && slot_free, step.load && !step.res.turn_on)
  `BSSU_ASSERT_SAME(a_done_is_last, clk, rst_n,
    step.load && state_r == S_DONE, step.res.last && !step.res.is_flip)
  `BSSU_ASSERT_SAME(a_clear_zeroes_store, clk, rst_n, state_r == S_DONE && clear_r,
    shown_r[0] == PAT_BLANK && shown_r[1] == PAT_BLANK &&
    shown_r[2] == PAT_BLANK && shown_r[3] == PAT_BLANK)

endmodule

// ===== sv/bistable_seven_segment_updater_top.sv =====
// ----------------------------------------------------------------------------
// bistable_seven_segment_updater_top
// Turns update and clear transactions into segment flip commands for a
// four-digit bistable seven-segment display.
// ----------------------------------------------------------------------------
// The input channel takes one transaction: a show request with two signed
// temperatures, or a clear request. The output channel carries one flip
// command for each segment that must change, digit 0 first and segment A
// first within a digit, and then one done marker with last set.
// After a transaction is accepted, the S_FMT state formats the four digit
// patterns, then a single bit compare walks the 28 segments at one segment per
// cycle while the output slot is free, and the S_DONE state issues the done
// marker. A new transaction is taken only once the done marker is loaded.
// Results pass through one output register. While the receiver stalls the
// walk holds its place, so nothing is lost. in_ready is high only while the
// sequencer is idle, which may already be while the done marker waits.
// Reset hides every stored segment and empties the output register.
// ----------------------------------------------------------------------------
module bistable_seven_segment_updater_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bssu_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bssu_pkg::out_item_t out_data
);
  import bssu_pkg::*;

  step_t     step;
  logic      slot_free;
  logic      out_valid_r;
  out_item_t out_data_r;

  assign slot_free = !out_valid_r || out_ready;

  bssu_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_ready  (in_ready),
    .slot_free (slot_free),
    .step      (step)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step.load) begin
      out_data_r <= step.res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
